// ----- sv/dems_pkg.sv -----
// Package for the dual encoder motor sync unit.
// Holds the transaction payload types, register indexes and code constants.
// No dependencies; every other file of the block imports it.
package dems_pkg;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int FRAC_BITS = 8;

	localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT_SPEED    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_SPEED        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT_GAIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_DEGREE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX          = 3'd5;

	localparam logic [1:0] ACT_TICK     = 2'd0;
	localparam logic [1:0] ACT_STRAIGHT = 2'd1;
	localparam logic [1:0] ACT_TURN     = 2'd2;
	localparam logic [1:0] ACT_BRAKE    = 2'd3;

	localparam logic [1:0] DIR_FORWARD = 2'd0;
	localparam logic [1:0] DIR_REVERSE = 2'd1;
	localparam logic [1:0] DIR_RIGHT   = 2'd2;
	localparam logic [1:0] DIR_LEFT    = 2'd3;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_STRAIGHT = 3'd1;
	localparam logic [2:0] ST_TURNING  = 3'd2;
	localparam logic [2:0] ST_DONE     = 3'd3;
	localparam logic [2:0] ST_REJECT   = 3'd4;

	typedef struct packed {
		logic [1:0] action;
		logic [1:0] direction;
		logic [7:0] angle;
		logic       enc_left_level;
		logic       enc_right_level;
	} cmd_t;

	typedef struct packed {
		logic [15:0] duty_left;
		logic [15:0] duty_right;
		logic        dir_left;
		logic        dir_right;
		logic [2:0]  status;
	} res_t;

	// Bit 0 is the left wheel and bit 1 the right wheel; a set bit means reverse.
	function automatic logic [1:0] dir_bits_of(input logic [1:0] code);
		logic [1:0] bits;
		case (code)
			DIR_FORWARD: bits = 2'b00;
			DIR_REVERSE: bits = 2'b11;
			DIR_RIGHT:   bits = 2'b10;
			DIR_LEFT:    bits = 2'b01;
			default:     bits = 2'b00;
		endcase
		return bits;
	endfunction

endpackage

// ----- sv/dems_if.sv -----
// Valid/ready channel interfaces for the dual encoder motor sync unit.
// Depends on dems_pkg for the command and result payload types.
interface dems_cmd_if import dems_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface dems_res_if import dems_pkg::*; ();
	logic valid;
	logic ready;
	res_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/dual_encoder_motor_sync_unit.sv -----
// Top level of the dual encoder motor sync unit: state, configuration and handshake.
// Depends on dems_pkg, the channel interfaces in dems_if and the dems_drive datapath.

// The unit takes one command or encoder tick per cycle while the result channel does not
// stall, and returns exactly one result transaction for each. A transaction is captured in
// an input stage; then the edge counts, the proportional correction (one 16 by COUNT_BITS
// multiply) and the duty clamp are worked out and written to the result register once
// that register is free or being taken, so a waiting result holds the input stage. While
// a result waits to be taken, the input stage can still accept one command. Configuration
// registers are written through wr_en, wr_index and wr_data; the user must write them only
// while no transaction is in flight, and the block itself does not enforce this.
module dual_encoder_motor_sync_unit import dems_pkg::*; #(
	parameter int COUNT_BITS = 16,
	parameter int DUTY_BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	dems_cmd_if.sink             cmd,
	dems_res_if.source           res
);

	localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
	localparam logic [15:0] DUTY_HW = 16'((1 << DUTY_BITS) - 1);
	localparam logic [15:0] TGT_MAX = (COUNT_BITS >= 16) ? 16'hFFFF :
		16'((1 << COUNT_BITS) - 1);

	typedef enum logic [1:0] {MODE_IDLE, MODE_STRAIGHT, MODE_TURN} mode_t;

	logic [CFG_W-1:0] straight_speed_q, turn_speed_q, straight_gain_q, turn_gain_q;
	logic [CFG_W-1:0] counts_per_degree_q, duty_max_q;

	cmd_t cmd_s1;
	logic valid_s1;
	logic res_valid_q;
	res_t res_q;
	logic advance;
	logic take;

	logic [COUNT_BITS-1:0] left_cnt_q, right_cnt_q;
	logic [COUNT_BITS-1:0] left_tick, right_tick;
	logic [COUNT_BITS-1:0] left_next, right_next;
	logic                  left_prev_q, right_prev_q;
	logic                  left_prev_next, right_prev_next;
	mode_t                 mode_q, mode_next;
	logic [15:0]           target_q, target_next, target_calc;
	logic [23:0]           target_prod;
	logic [1:0]            dir_q, dir_next;
	logic [DUTY_BITS-1:0]  duty_l_q, duty_r_q, duty_l_next, duty_r_next;
	logic [DUTY_BITS-1:0]  drv_l, drv_r, duty_lim;
	logic [DUTY_BITS-1:0]  drv_left_cnt_unused;
	logic [COUNT_BITS-1:0] drv_left, drv_right;
	logic                  use_straight;
	logic                  is_start;
	logic [2:0]            status;

	assign advance   = !res_valid_q || res.ready;
	assign take      = valid_s1 && advance;
	assign cmd.ready = !valid_s1 || advance;
	assign res.valid = res_valid_q;
	assign res.payload = res_q;

	assign left_tick  = left_cnt_q + COUNT_BITS'(cmd_s1.enc_left_level != left_prev_q);
	assign right_tick = right_cnt_q + COUNT_BITS'(cmd_s1.enc_right_level != right_prev_q);
	assign is_start   = (cmd_s1.action == ACT_STRAIGHT) || (cmd_s1.action == ACT_TURN);
	assign drv_left   = is_start ? '0 : left_tick;
	assign drv_right  = is_start ? '0 : right_tick;
	assign use_straight = (cmd_s1.action == ACT_STRAIGHT) ||
		((cmd_s1.action == ACT_TICK) && (mode_q == MODE_STRAIGHT));
	assign duty_lim   = (duty_max_q > DUTY_HW) ? DUTY_HW[DUTY_BITS-1:0] :
		duty_max_q[DUTY_BITS-1:0];
	assign drv_left_cnt_unused = '0;

	assign target_prod = 24'(cmd_s1.angle) * 24'(counts_per_degree_q);
	assign target_calc = (target_prod[23:FRAC_BITS] > TGT_MAX) ? TGT_MAX :
		target_prod[23:FRAC_BITS];

	dems_drive #(
		.COUNT_BITS(COUNT_BITS),
		.DUTY_BITS (DUTY_BITS)
	) u_drive (
		.speed      (use_straight ? straight_speed_q : turn_speed_q),
		.gain       (use_straight ? straight_gain_q : turn_gain_q),
		.left_count (drv_left),
		.right_count(drv_right),
		.limit      (duty_lim | drv_left_cnt_unused),
		.duty_left  (drv_l),
		.duty_right (drv_r)
	);

	always_comb begin
		left_next       = left_cnt_q;
		right_next      = right_cnt_q;
		left_prev_next  = left_prev_q;
		right_prev_next = right_prev_q;
		mode_next       = mode_q;
		target_next     = target_q;
		dir_next        = dir_q;
		duty_l_next     = duty_l_q;
		duty_r_next     = duty_r_q;
		status          = ST_IDLE;
		case (cmd_s1.action)
			ACT_TICK: begin
				left_next       = left_tick;
				right_next      = right_tick;
				left_prev_next  = cmd_s1.enc_left_level;
				right_prev_next = cmd_s1.enc_right_level;
				if (mode_q == MODE_STRAIGHT) begin
					duty_l_next = drv_l;
					duty_r_next = drv_r;
					status      = ST_STRAIGHT;
				end else if (mode_q == MODE_TURN) begin
					if (CMP_W'(right_tick) >= CMP_W'(target_q)) begin
						duty_l_next = '0;
						duty_r_next = '0;
						mode_next   = MODE_IDLE;
						status      = ST_DONE;
					end else begin
						duty_l_next = drv_l;
						duty_r_next = drv_r;
						status      = ST_TURNING;
					end
				end
			end
			ACT_STRAIGHT: begin
				if (cmd_s1.direction == DIR_RIGHT || cmd_s1.direction == DIR_LEFT) begin
					status = ST_REJECT;
				end else begin
					dir_next    = dir_bits_of(cmd_s1.direction);
					left_next   = '0;
					right_next  = '0;
					mode_next   = MODE_STRAIGHT;
					duty_l_next = drv_l;
					duty_r_next = drv_r;
					status      = ST_STRAIGHT;
				end
			end
			ACT_TURN: begin
				target_next = target_calc;
				dir_next    = dir_bits_of(cmd_s1.direction);
				left_next   = '0;
				right_next  = '0;
				if (target_calc == '0) begin
					duty_l_next = '0;
					duty_r_next = '0;
					mode_next   = MODE_IDLE;
					status      = ST_DONE;
				end else begin
					duty_l_next = drv_l;
					duty_r_next = drv_r;
					mode_next   = MODE_TURN;
					status      = ST_TURNING;
				end
			end
			ACT_BRAKE: begin
				duty_l_next = '0;
				duty_r_next = '0;
				mode_next   = MODE_IDLE;
				status      = ST_IDLE;
			end
			default: begin
				status = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			straight_speed_q    <= 16'd1023;
			turn_speed_q        <= 16'd512;
			straight_gain_q     <= 16'd256;
			turn_gain_q         <= 16'd256;
			counts_per_degree_q <= 16'd256;
			duty_max_q          <= 16'd1023;
		end else if (wr_en) begin
			case (wr_index)
				REG_STRAIGHT_SPEED:    straight_speed_q    <= wr_data;
				REG_TURN_SPEED:        turn_speed_q        <= wr_data;
				REG_STRAIGHT_GAIN:     straight_gain_q     <= wr_data;
				REG_TURN_GAIN:         turn_gain_q         <= wr_data;
				REG_COUNTS_PER_DEGREE: counts_per_degree_q <= wr_data;
				REG_DUTY_MAX:          duty_max_q          <= wr_data;
				default:               ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= cmd.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			res_valid_q  <= 1'b0;
			res_q        <= '0;
			left_cnt_q   <= '0;
			right_cnt_q  <= '0;
			left_prev_q  <= 1'b0;
			right_prev_q <= 1'b0;
			mode_q       <= MODE_IDLE;
			target_q     <= '0;
			dir_q        <= 2'b00;
			duty_l_q     <= '0;
			duty_r_q     <= '0;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (advance) begin
				res_valid_q <= valid_s1;
			end
			if (take) begin
				left_cnt_q         <= left_next;
				right_cnt_q        <= right_next;
				left_prev_q        <= left_prev_next;
				right_prev_q       <= right_prev_next;
				mode_q             <= mode_next;
				target_q           <= target_next;
				dir_q              <= dir_next;
				duty_l_q           <= duty_l_next;
				duty_r_q           <= duty_r_next;
				res_q.duty_left    <= 16'(duty_l_next);
				res_q.duty_right   <= 16'(duty_r_next);
				res_q.dir_left     <= dir_next[0];
				res_q.dir_right    <= dir_next[1];
				res_q.status       <= status;
			end
		end
	end

`ifndef SYNTH
	a_done_braked: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.status == ST_DONE |-> res_q.duty_left == '0 &&
		res_q.duty_right == '0)
		else $error("turn done reported with nonzero duty");

	// A rejected command carries duties worked out under an earlier clamp.
	a_duty_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.status != ST_REJECT |->
		res_q.duty_left <= duty_max_q && res_q.duty_right <= duty_max_q)
		else $error("duty above clamp");

	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		take && cmd_s1.action == ACT_TICK && mode_q == MODE_IDLE |=>
		res_q.status == ST_IDLE && mode_q == MODE_IDLE)
		else $error("tick while idle changed mode or status");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && cmd_s1.action == ACT_STRAIGHT &&
		(cmd_s1.direction == DIR_FORWARD || cmd_s1.direction == DIR_REVERSE) |=>
		left_cnt_q == '0 && right_cnt_q == '0 && mode_q == MODE_STRAIGHT)
		else $error("start straight did not clear counts");
`endif

endmodule

// ----- sv/dems_drive.sv -----
// Proportional wheel balance: duty = speed +/- trunc(gain * |right - left| / 2^FRAC_BITS), clamped to limit.
// Purely combinational; depends on dems_pkg for the gain fraction width.
module dems_drive import dems_pkg::*; #(
	parameter int COUNT_BITS = 16,
	parameter int DUTY_BITS  = 16
) (
	input  logic [15:0]           speed,
	input  logic [15:0]           gain,
	input  logic [COUNT_BITS-1:0] left_count,
	input  logic [COUNT_BITS-1:0] right_count,
	input  logic [DUTY_BITS-1:0]  limit,
	output logic [DUTY_BITS-1:0]  duty_left,
	output logic [DUTY_BITS-1:0]  duty_right
);

	localparam int PROD_W = COUNT_BITS + 16;
	localparam int ADJ_W  = PROD_W - FRAC_BITS;
	localparam int SUM_W  = COUNT_BITS + 10;

	logic signed [COUNT_BITS:0] diff;
	logic                       neg;
	logic [COUNT_BITS-1:0]      mag;
	logic [PROD_W-1:0]          prod;
	logic [ADJ_W-1:0]           adj;
	logic signed [SUM_W-1:0]    adj_s;
	logic signed [SUM_W-1:0]    speed_s;
	logic signed [SUM_W-1:0]    limit_s;
	logic signed [SUM_W-1:0]    sum_l;
	logic signed [SUM_W-1:0]    sum_r;

	assign diff    = signed'({1'b0, right_count}) - signed'({1'b0, left_count});
	assign neg     = diff[COUNT_BITS];
	assign mag     = neg ? COUNT_BITS'(-diff) : COUNT_BITS'(diff);
	assign prod    = PROD_W'(gain) * PROD_W'(mag);
	assign adj     = prod[PROD_W-1:FRAC_BITS];
	assign adj_s   = signed'(SUM_W'(adj));
	assign speed_s = signed'(SUM_W'(speed));
	assign limit_s = signed'(SUM_W'(limit));
	assign sum_l   = neg ? speed_s - adj_s : speed_s + adj_s;
	assign sum_r   = neg ? speed_s + adj_s : speed_s - adj_s;

	always_comb begin
		if (sum_l < 0) begin
			duty_left = '0;
		end else if (sum_l > limit_s) begin
			duty_left = limit;
		end else begin
			duty_left = sum_l[DUTY_BITS-1:0];
		end
		if (sum_r < 0) begin
			duty_right = '0;
		end else if (sum_r > limit_s) begin
			duty_right = limit;
		end else begin
			duty_right = sum_r[DUTY_BITS-1:0];
		end
	end

endmodule
